FILE: src/ppsr_pkg.sv
package ppsr_pkg;

	// Operation codes carried in the opcode field of an input item.
	typedef enum logic [2:0] {
		OP_PLOT       = 3'd0,
		OP_LOAD_BOUND = 3'd1,
		OP_LOAD_COLOR = 3'd2,
		OP_READ       = 3'd3,
		OP_CLEAR      = 3'd4
	} opcode_t;

	// Result status codes.
	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_CLIP = 2'd1;
	localparam logic [1:0] STATUS_SLOT = 2'd2;

	// Configuration register indexes.
	localparam int         CFG_IDX_W          = 2;
	localparam logic [1:0] CFG_PIXEL_GAIN     = 2'd0;
	localparam logic [1:0] CFG_BOUNDARY_COUNT = 2'd1;

	// Gain of 1.0 in Q16.16.
	localparam logic [31:0] GAIN_RESET = 32'h0001_0000;

	typedef struct packed {
		logic [2:0]         opcode;
		logic [63:0]        particle_key;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [14:0]        slot;
		logic [63:0]        load_value;
	} in_item_t;

	typedef struct packed {
		logic [23:0] pixel_color;
		logic [4:0]  owner;
		logic [1:0]  status;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_MAP,
		ST_WRL,
		ST_WRR,
		ST_CLEAR,
		ST_DONE
	} state_t;

	// Controls for the boundary/palette unit.
	typedef struct packed {
		logic bnd_we;
		logic pal_we;
		logic match_en;
		logic lookup_en;
	} tbl_ctrl_t;

	// Result of the range search: owner index and its palette colour.
	typedef struct packed {
		logic [23:0] color;
		logic [4:0]  owner;
	} match_res_t;

	// Controls for the coordinate pipeline.
	typedef struct packed {
		logic calc_en;
		logic map_en;
	} coord_ctrl_t;

	// Per-axis in-image flags from the coordinate pipeline.
	typedef struct packed {
		logic x;
		logic y;
		logic z;
	} coord_ok_t;

endpackage

FILE: src/ppsr_pixel_store.sv
module ppsr_pixel_store #(
	parameter int DEPTH  = 32768,
	parameter int ADDR_W = 15
) (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [ADDR_W-1:0] addr,
	input  logic [23:0]       wdata,
	output logic [23:0]       rdata
);

	logic [23:0] mem [DEPTH];
	logic [23:0] rdata_q;

	// Single port: one address per cycle, used for a write, a registered read or both.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/ppsr_coord_map.sv
module ppsr_coord_map #(
	parameter int IMG_HEIGHT = 128,
	parameter int CW         = 7
) (
	input  logic                   clk,
	input  ppsr_pkg::coord_ctrl_t  ctrl,
	input  logic [31:0]            gain,
	input  logic signed [31:0]     pos_x,
	input  logic signed [31:0]     pos_y,
	input  logic signed [31:0]     pos_z,
	output logic [CW-1:0]          coord_x,
	output logic [CW-1:0]          coord_y,
	output logic [CW-1:0]          coord_z,
	output ppsr_pkg::coord_ok_t    coord_ok
);

	// Image center plus the rounding half, both at Q32.32.
	localparam logic signed [65:0] OFFSET = 66'(IMG_HEIGHT + 1) << 31;

	logic signed [31:0] pos      [3];
	logic signed [64:0] prod_s1  [3];
	logic signed [65:0] sum      [3];
	logic               ok       [3];
	logic [CW-1:0]      coord_s2 [3];
	logic               ok_s2    [3];

	always_comb begin
		pos[0] = pos_x;
		pos[1] = pos_y;
		pos[2] = pos_z;
	end

	// Stage 1: one signed-by-unsigned product per axis.
	always_ff @(posedge clk) begin
		if (ctrl.calc_en) begin
			for (int i = 0; i < 3; i++) begin
				prod_s1[i] <= pos[i] * $signed({1'b0, gain});
			end
		end
	end

	// A coordinate lands in the image exactly when the biased sum is positive
	// and its integer part is below the image height.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum[i] = {prod_s1[i][64], prod_s1[i]} + OFFSET;
			ok[i]  = !sum[i][65] && (sum[i] != '0) &&
				(sum[i][65:32] < 34'(IMG_HEIGHT));
		end
	end

	// Stage 2: integer coordinate and in-image flag.
	always_ff @(posedge clk) begin
		if (ctrl.map_en) begin
			for (int i = 0; i < 3; i++) begin
				coord_s2[i] <= sum[i][32 +: CW];
				ok_s2[i]    <= ok[i];
			end
		end
	end

	assign coord_x    = coord_s2[0];
	assign coord_y    = coord_s2[1];
	assign coord_z    = coord_s2[2];
	assign coord_ok.x = ok_s2[0];
	assign coord_ok.y = ok_s2[1];
	assign coord_ok.z = ok_s2[2];

endmodule

FILE: src/ppsr_range_match.sv
module ppsr_range_match #(
	parameter int MAX_PROCS = 16
) (
	input  logic                  clk,
	input  ppsr_pkg::tbl_ctrl_t   ctrl,
	input  logic [14:0]           slot,
	input  logic [63:0]           load_value,
	input  logic [63:0]           key,
	input  logic [4:0]            bcount,
	output ppsr_pkg::match_res_t  res
);

	localparam int BOUND_DEPTH = MAX_PROCS + 1;
	localparam int BW          = $clog2(BOUND_DEPTH);
	localparam int PW          = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;

	logic [63:0]          bnd_q [BOUND_DEPTH];
	logic [23:0]          pal_mem [2**PW];
	logic [MAX_PROCS-1:0] match_s1;
	logic [PW-1:0]        sel;
	logic                 found;
	logic [23:0]          pal_rd_q;
	logic                 hit_q;
	logic [4:0]           owner_q;

	// Boundaries live in registers so every range is compared at once.
	always_ff @(posedge clk) begin
		if (ctrl.bnd_we) begin
			bnd_q[slot[BW-1:0]] <= load_value;
		end
	end

	// Range p is live only when both of its boundaries are in use.
	always_ff @(posedge clk) begin
		if (ctrl.match_en) begin
			for (int p = 0; p < MAX_PROCS; p++) begin
				match_s1[p] <= (key > bnd_q[p]) && (key < bnd_q[p + 1]) &&
					((p + 2) <= int'(bcount));
			end
		end
	end

	// Lowest matching range wins.
	always_comb begin
		sel   = '0;
		found = 1'b0;
		for (int p = MAX_PROCS - 1; p >= 0; p--) begin
			if (match_s1[p]) begin
				sel   = PW'(p);
				found = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.pal_we) begin
			pal_mem[slot[PW-1:0]] <= load_value[23:0];
		end
		if (ctrl.lookup_en) begin
			pal_rd_q <= pal_mem[sel];
			hit_q    <= found;
			owner_q  <= found ? 5'(sel) : 5'(MAX_PROCS);
		end
	end

	assign res.color = hit_q ? pal_rd_q : 24'h0;
	assign res.owner = owner_q;

endmodule

FILE: src/particle_point_splat_renderer_top.sv
// Side-by-side point-splat renderer. The image is IMG_HEIGHT rows by
// 2*IMG_HEIGHT columns: the left half shows the x-y plane, the right half x-z.
// Input channel (in_valid/in_ready/in_data) carries one command per transfer:
// plot a particle, load a range boundary, load a palette colour, read a pixel,
// or clear the image. Every command yields exactly one result transfer on
// out_valid/out_ready/out_data. The configuration channel writes pixel_gain
// (index 0) and boundary_count (index 1); it is always ready and should only
// be used while no command is in flight.
// One command is worked on at a time: a plot multiplies and looks up its range,
// then writes its two pixels one after the other through the single port of
// the pixel store; a load or read finishes in a single step, and a clear
// sweeps the whole store before its result is given.
// After reset the pixel store is swept to black, one pixel per cycle, over all
// 2*IMG_HEIGHT*IMG_HEIGHT pixels; in_ready stays low during that sweep.
// A finished result sits in an output register; the next command can be
// transferred while it waits, but that command's result is held back until
// the receiver has taken the previous one.
module particle_point_splat_renderer_top #(
	parameter int IMG_HEIGHT = 128,
	parameter int MAX_PROCS  = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  ppsr_pkg::in_item_t                in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output ppsr_pkg::out_item_t               out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ppsr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                       cfg_data
);

	localparam int PIX_COUNT   = 2 * IMG_HEIGHT * IMG_HEIGHT;
	localparam int PIX_AW      = $clog2(PIX_COUNT);
	localparam int CW          = $clog2(IMG_HEIGHT);
	localparam int ROW         = 2 * IMG_HEIGHT;
	localparam int BOUND_DEPTH = MAX_PROCS + 1;

	ppsr_pkg::state_t      state_q;
	ppsr_pkg::state_t      state_d;
	ppsr_pkg::in_item_t    item_q;
	ppsr_pkg::out_item_t   out_q;
	ppsr_pkg::out_item_t   res_d;
	ppsr_pkg::tbl_ctrl_t   tbl_ctrl;
	ppsr_pkg::coord_ctrl_t coord_ctrl;
	ppsr_pkg::match_res_t  match_res;
	ppsr_pkg::coord_ok_t   coord_ok;

	logic [31:0]       gain_q;
	logic [4:0]        bcount_q;
	logic              out_valid_q;
	logic              out_load;
	logic [PIX_AW-1:0] clr_q;
	logic              clr_last;
	logic              sweeping;

	logic              bnd_slot_ok;
	logic              pal_slot_ok;
	logic              pix_slot_ok;
	logic              left_ok;
	logic              right_ok;

	logic [CW-1:0]     coord_x;
	logic [CW-1:0]     coord_y;
	logic [CW-1:0]     coord_z;
	logic [PIX_AW-1:0] left_addr;
	logic [PIX_AW-1:0] right_addr;

	logic              pix_we;
	logic              pix_re;
	logic [PIX_AW-1:0] pix_addr;
	logic [23:0]       pix_wdata;
	logic [23:0]       pix_rdata;

	// Configuration registers. Writes to unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= ppsr_pkg::GAIN_RESET;
			bcount_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				ppsr_pkg::CFG_PIXEL_GAIN:     gain_q   <= cfg_data;
				ppsr_pkg::CFG_BOUNDARY_COUNT: bcount_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// The accepted command is held for the whole of its processing.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= in_data;
		end
	end

	assign bnd_slot_ok = int'(item_q.slot) < BOUND_DEPTH;
	assign pal_slot_ok = int'(item_q.slot) < MAX_PROCS;
	assign pix_slot_ok = int'(item_q.slot) < PIX_COUNT;

	ppsr_range_match #(
		.MAX_PROCS (MAX_PROCS)
	) u_range_match (
		.clk        (clk),
		.ctrl       (tbl_ctrl),
		.slot       (item_q.slot),
		.load_value (item_q.load_value),
		.key        (item_q.particle_key),
		.bcount     (bcount_q),
		.res        (match_res)
	);

	ppsr_coord_map #(
		.IMG_HEIGHT (IMG_HEIGHT),
		.CW         (CW)
	) u_coord_map (
		.clk      (clk),
		.ctrl     (coord_ctrl),
		.gain     (gain_q),
		.pos_x    (item_q.pos_x),
		.pos_y    (item_q.pos_y),
		.pos_z    (item_q.pos_z),
		.coord_x  (coord_x),
		.coord_y  (coord_y),
		.coord_z  (coord_z),
		.coord_ok (coord_ok)
	);

	// The left plane occupies columns 0..H-1 of each row, the right plane H..2H-1.
	assign left_ok    = coord_ok.x && coord_ok.y;
	assign right_ok   = coord_ok.x && coord_ok.z;
	assign left_addr  = PIX_AW'(PIX_AW'(coord_y) * PIX_AW'(ROW) + PIX_AW'(coord_x));
	assign right_addr = PIX_AW'(PIX_AW'(coord_z) * PIX_AW'(ROW) + PIX_AW'(coord_x)
		+ PIX_AW'(IMG_HEIGHT));

	ppsr_pixel_store #(
		.DEPTH  (PIX_COUNT),
		.ADDR_W (PIX_AW)
	) u_pixel_store (
		.clk   (clk),
		.we    (pix_we),
		.re    (pix_re),
		.addr  (pix_addr),
		.wdata (pix_wdata),
		.rdata (pix_rdata)
	);

	// Clear sweep counter. It returns to zero at the end of every sweep, so a
	// new sweep always starts from the first pixel.
	assign sweeping = (state_q == ppsr_pkg::ST_INIT) || (state_q == ppsr_pkg::ST_CLEAR);
	assign clr_last = (clr_q == PIX_AW'(PIX_COUNT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (sweeping) begin
			clr_q <= clr_last ? '0 : PIX_AW'(clr_q + 1'b1);
		end
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppsr_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ppsr_pkg::ST_INIT: begin
				if (clr_last) state_d = ppsr_pkg::ST_IDLE;
			end
			ppsr_pkg::ST_IDLE: begin
				if (in_valid) state_d = ppsr_pkg::ST_EXEC;
			end
			ppsr_pkg::ST_EXEC: begin
				case (item_q.opcode)
					ppsr_pkg::OP_PLOT:  state_d = ppsr_pkg::ST_MAP;
					ppsr_pkg::OP_CLEAR: state_d = ppsr_pkg::ST_CLEAR;
					default:            state_d = ppsr_pkg::ST_DONE;
				endcase
			end
			ppsr_pkg::ST_MAP:   state_d = ppsr_pkg::ST_WRL;
			ppsr_pkg::ST_WRL:   state_d = ppsr_pkg::ST_WRR;
			ppsr_pkg::ST_WRR:   state_d = ppsr_pkg::ST_DONE;
			ppsr_pkg::ST_CLEAR: begin
				if (clr_last) state_d = ppsr_pkg::ST_DONE;
			end
			ppsr_pkg::ST_DONE: begin
				if (out_load) state_d = ppsr_pkg::ST_IDLE;
			end
			default: state_d = ppsr_pkg::ST_INIT;
		endcase
	end

	// Sequencer outputs: store port, table and pipeline controls.
	always_comb begin
		in_ready   = 1'b0;
		tbl_ctrl   = '0;
		coord_ctrl = '0;
		pix_we     = 1'b0;
		pix_re     = 1'b0;
		pix_addr   = clr_q;
		pix_wdata  = 24'h0;
		case (state_q)
			ppsr_pkg::ST_INIT, ppsr_pkg::ST_CLEAR: begin
				pix_we = 1'b1;
			end
			ppsr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			ppsr_pkg::ST_EXEC: begin
				case (item_q.opcode)
					ppsr_pkg::OP_PLOT: begin
						coord_ctrl.calc_en = 1'b1;
						tbl_ctrl.match_en  = 1'b1;
					end
					ppsr_pkg::OP_LOAD_BOUND: tbl_ctrl.bnd_we = bnd_slot_ok;
					ppsr_pkg::OP_LOAD_COLOR: tbl_ctrl.pal_we = pal_slot_ok;
					ppsr_pkg::OP_READ: begin
						pix_re   = pix_slot_ok;
						pix_addr = PIX_AW'(item_q.slot);
					end
					default: ;
				endcase
			end
			ppsr_pkg::ST_MAP: begin
				coord_ctrl.map_en  = 1'b1;
				tbl_ctrl.lookup_en = 1'b1;
			end
			ppsr_pkg::ST_WRL: begin
				pix_we    = left_ok;
				pix_addr  = left_addr;
				pix_wdata = match_res.color;
			end
			ppsr_pkg::ST_WRR: begin
				pix_we    = right_ok;
				pix_addr  = right_addr;
				pix_wdata = match_res.color;
			end
			default: ;
		endcase
	end

	// Result assembly. Everything it reads is held stable while in ST_DONE.
	always_comb begin
		res_d = '0;
		case (item_q.opcode)
			ppsr_pkg::OP_PLOT: begin
				res_d.pixel_color = match_res.color;
				res_d.owner       = match_res.owner;
				res_d.status      = (left_ok && right_ok) ? ppsr_pkg::STATUS_OK
					: ppsr_pkg::STATUS_CLIP;
			end
			ppsr_pkg::OP_LOAD_BOUND: begin
				res_d.status = bnd_slot_ok ? ppsr_pkg::STATUS_OK : ppsr_pkg::STATUS_SLOT;
			end
			ppsr_pkg::OP_LOAD_COLOR: begin
				res_d.status = pal_slot_ok ? ppsr_pkg::STATUS_OK : ppsr_pkg::STATUS_SLOT;
			end
			ppsr_pkg::OP_READ: begin
				res_d.pixel_color = pix_slot_ok ? pix_rdata : 24'h0;
				res_d.status      = pix_slot_ok ? ppsr_pkg::STATUS_OK
					: ppsr_pkg::STATUS_SLOT;
			end
			default: ;
		endcase
	end

	// Output register: loaded when the slot is empty or being emptied.
	assign out_load = (state_q == ppsr_pkg::ST_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// No command is taken while the store is being swept.
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		sweeping |-> !in_ready)
		else $error("command accepted during clear sweep");

	// The sweep visits consecutive pixels.
	a_sweep_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(sweeping && !clr_last) |=> (clr_q == PIX_AW'($past(clr_q) + 1'b1)))
		else $error("clear sweep skipped a pixel");

	// The right-plane write always directly follows the left-plane write.
	a_wrr_after_wrl: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ppsr_pkg::ST_WRR) |-> ($past(state_q) == ppsr_pkg::ST_WRL))
		else $error("right write without left write");

	// A waiting result is never overwritten before it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(out_q)))
		else $error("pending result lost");

endmodule
